[hw/rtl/imusfd_pkg.sv]
package imusfd_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_RATE   = 8'h52;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;

   localparam logic [1:0] KIND_ACCEL = 2'd0;
   localparam logic [1:0] KIND_RATE  = 2'd1;
   localparam logic [1:0] KIND_ANGLE = 2'd2;

   // frame byte positions
   localparam logic [3:0] POS_FIRST_DATA = 4'd1;
   localparam logic [3:0] POS_CHECK      = 4'd10;
   localparam int         STORE_DEPTH    = 8;
   localparam int         TYPE_POS       = 1;
   localparam int         DATA_POS       = 2;
   localparam int         AXES           = 3;
   localparam int         LATEST_DEPTH   = 9;

   typedef logic signed [15:0] sample_type;
   typedef sample_type [AXES-1:0] triple_type;
   typedef sample_type [LATEST_DEPTH-1:0] latest_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      triple_type value;
   } frame_event_type;

endpackage

[hw/rtl/imusfd_req_if.sv]
interface imusfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/imusfd_rsp_if.sv]
interface imusfd_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             frame_kind;
   imusfd_pkg::sample_type accel_x;
   imusfd_pkg::sample_type accel_y;
   imusfd_pkg::sample_type accel_z;
   imusfd_pkg::sample_type rate_x;
   imusfd_pkg::sample_type rate_y;
   imusfd_pkg::sample_type rate_z;
   imusfd_pkg::sample_type angle_x;
   imusfd_pkg::sample_type angle_y;
   imusfd_pkg::sample_type angle_z;

   modport source (output valid, output frame_kind, output accel_x, output accel_y,
                   output accel_z, output rate_x, output rate_y, output rate_z,
                   output angle_x, output angle_y, output angle_z, input ready);
   modport sink (input valid, input frame_kind, input accel_x, input accel_y,
                 input accel_z, input rate_x, input rate_y, input rate_z,
                 input angle_x, input angle_y, input angle_z, output ready);
endinterface

[hw/rtl/imusfd_parser.sv]
module imusfd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [7:0]                  rx_byte,
   output imusfd_pkg::frame_event_type frame_event
);
   import imusfd_pkg::*;

   localparam int IDX_BITS = $clog2(STORE_DEPTH);

   logic       open_ff, open_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       store_we;
   logic [7:0] store_ff [STORE_DEPTH];
   logic       kind_ok;
   logic [1:0] kind;

   always_comb begin
      case (store_ff[IDX_BITS'(TYPE_POS)])
         TYPE_ACCEL: begin kind = KIND_ACCEL; kind_ok = 1'b1; end
         TYPE_RATE:  begin kind = KIND_RATE;  kind_ok = 1'b1; end
         TYPE_ANGLE: begin kind = KIND_ANGLE; kind_ok = 1'b1; end
         default:    begin kind = KIND_ACCEL; kind_ok = 1'b0; end
      endcase
   end

   always_comb begin
      open_in = open_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      store_we = 1'b0;
      frame_event.valid = 1'b0;
      frame_event.kind = kind;
      for (int i = 0; i < AXES; i++) begin
         frame_event.value[i] = {store_ff[IDX_BITS'(DATA_POS + 2*i + 1)],
                                 store_ff[IDX_BITS'(DATA_POS + 2*i)]};
      end
      if (fire) begin
         if (!open_ff) begin
            if (rx_byte == HEADER_BYTE) begin
               open_in = 1'b1;
               pos_in = POS_FIRST_DATA;
               sum_in = rx_byte;
            end
         end else if (pos_ff == POS_CHECK) begin
            open_in = 1'b0;
            pos_in = '0;
            frame_event.valid = (rx_byte == sum_ff) && kind_ok;
         end else begin
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 4'd1;
            store_we = (pos_ff < 4'(STORE_DEPTH));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         open_ff <= open_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[pos_ff[IDX_BITS-1:0]] <= rx_byte;
      end
   end

endmodule

[hw/rtl/imusfd_latest.sv]
module imusfd_latest (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  imusfd_pkg::frame_event_type frame_event,
   output imusfd_pkg::latest_type      latest
);
   import imusfd_pkg::*;

   latest_type latest_ff, latest_in;

   always_comb begin
      latest_in = latest_ff;
      if (fire && frame_event.valid) begin
         case (frame_event.kind)
            KIND_ACCEL: begin
               for (int i = 0; i < AXES; i++) latest_in[i] = frame_event.value[i];
            end
            KIND_RATE: begin
               for (int i = 0; i < AXES; i++) latest_in[AXES + i] = frame_event.value[i];
            end
            KIND_ANGLE: begin
               for (int i = 0; i < AXES; i++) latest_in[2*AXES + i] = frame_event.value[i];
            end
            default: begin
               latest_in = latest_ff;
            end
         endcase
      end
   end

   assign latest = latest_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff <= '0;
      end else begin
         latest_ff <= latest_in;
      end
   end

endmodule

[hw/rtl/imu_serial_frame_decoder.sv]
// Decodes the 11-byte frames of an inertial sensor's serial stream, one received byte per
// req beat. A 0x55 byte seen while no frame is open starts a frame; the eleventh byte must
// equal the modulo-256 sum of the first ten. Frames of type 0x51, 0x52 and 0x53 replace the
// acceleration, angular rate or angle triple and produce one rsp beat that carries the kind
// and all nine latest raw counts (LSB 16/32768 g, 2000/32768 deg/s, 180/32768 deg); bad
// checksums and unknown types produce nothing. A byte is taken every cycle while req.ready is
// high; the checksum byte is checked from the input register and the rsp beat for its frame
// is then held in the rsp output register until it is taken, and a stalled rsp holds back req
// only once the input register is also full.
module imu_serial_frame_decoder (
   input  logic          clock,
   input  logic          reset,
   imusfd_req_if.sink    req,
   imusfd_rsp_if.source  rsp
);
   import imusfd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   latest_type      values_ff, values_in;
   logic            advance;
   logic            work;
   frame_event_type frame_event;
   latest_type      latest;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign work = in_valid_ff && advance;

   imusfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (work),
      .rx_byte     (in_byte_ff),
      .frame_event (frame_event)
   );

   imusfd_latest u_latest (
      .clock       (clock),
      .reset       (reset),
      .fire        (work),
      .frame_event (frame_event),
      .latest      (latest)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         if (req.valid) in_byte_in = req.rx_byte;
      end
      rsp_valid_in = rsp_valid_ff;
      kind_in = kind_ff;
      values_in = values_ff;
      if (advance) begin
         rsp_valid_in = work && frame_event.valid;
         if (work && frame_event.valid) begin
            kind_in = frame_event.kind;
            values_in = latest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      kind_ff <= kind_in;
      values_ff <= values_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frame_kind = kind_ff;
   assign rsp.accel_x = values_ff[0];
   assign rsp.accel_y = values_ff[1];
   assign rsp.accel_z = values_ff[2];
   assign rsp.rate_x = values_ff[3];
   assign rsp.rate_y = values_ff[4];
   assign rsp.rate_z = values_ff[5];
   assign rsp.angle_x = values_ff[6];
   assign rsp.angle_y = values_ff[7];
   assign rsp.angle_z = values_ff[8];

endmodule

[tb/imusfd_report_checker.sv]
module imusfd_report_checker (
   input  logic  clock,
   input  logic  reset,
   imusfd_req_if req,
   imusfd_rsp_if rsp,
   output int    mismatches,
   output int    reports_due,
   output int    reports_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import imusfd_pkg::*;

   localparam int FRAME_BYTES = 11;
   localparam int FIELDS      = 10;
   localparam int PRINT_CAP   = 50;

   typedef struct packed {
      logic [1:0] kind;
      latest_type vals;
   } imu_report_type;

   imu_report_type pending_reports[$];

   logic       frame_open_q;
   logic [3:0] bytes_left;
   logic [7:0] frame_sum;
   logic [7:0] frame_bytes [10];
   latest_type latest;
   int         error_total;
   int         beat_total;

   string field_name [FIELDS] = '{"frame_kind", "accel_x", "accel_y", "accel_z",
                                  "rate_x", "rate_y", "rate_z",
                                  "angle_x", "angle_y", "angle_z"};

   // running frame parser and latest-value store
   task automatic absorb_byte(input logic [7:0] b);
      int unsigned    pos;
      int unsigned    base;
      logic [1:0]     kind;
      imu_report_type rep;
      if (!frame_open_q && b == HEADER_BYTE) begin
         frame_open_q = 1'b1;
         bytes_left   = 4'(FRAME_BYTES);
         frame_sum    = '0;
      end
      if (!frame_open_q) return;
      pos        = FRAME_BYTES - bytes_left;
      bytes_left = bytes_left - 4'd1;
      if (pos < POS_CHECK) begin
         frame_bytes[pos] = b;
         frame_sum        = frame_sum + b;
         return;
      end
      frame_open_q = 1'b0;
      bytes_left   = '0;
      if (b != frame_sum) return;
      case (frame_bytes[TYPE_POS])
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_RATE:  kind = KIND_RATE;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default:    return;
      endcase
      base = kind * AXES;
      for (int i = 0; i < AXES; i++) begin
         latest[base + i] = {frame_bytes[DATA_POS + 2 * i + 1], frame_bytes[DATA_POS + 2 * i]};
      end
      rep.kind = kind;
      rep.vals = latest;
      pending_reports.push_back(rep);
   endtask

   task automatic check_report();
      imu_report_type want;
      logic [15:0]    got_f  [FIELDS];
      logic [15:0]    want_f [FIELDS];
      got_f[0] = {14'd0, rsp.frame_kind};
      got_f[1] = rsp.accel_x;
      got_f[2] = rsp.accel_y;
      got_f[3] = rsp.accel_z;
      got_f[4] = rsp.rate_x;
      got_f[5] = rsp.rate_y;
      got_f[6] = rsp.rate_z;
      got_f[7] = rsp.angle_x;
      got_f[8] = rsp.angle_y;
      got_f[9] = rsp.angle_z;
      beat_total++;
      if (pending_reports.size() == 0) begin
         error_total++;
         if (error_total <= PRINT_CAP)
            $display("%0t: report beat %0d: expected none, got kind %h", $realtime,
                     beat_total, got_f[0]);
         return;
      end
      want = pending_reports.pop_front();
      want_f[0] = {14'd0, want.kind};
      for (int i = 0; i < LATEST_DEPTH; i++) want_f[i + 1] = want.vals[i];
      for (int i = 0; i < FIELDS; i++) begin
         if (got_f[i] !== want_f[i]) begin
            error_total++;
            if (error_total <= PRINT_CAP)
               $display("%0t: report beat %0d %s: expected %h, got %h", $realtime,
                        beat_total, field_name[i], want_f[i], got_f[i]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_reports.delete();
         frame_open_q = 1'b0;
         bytes_left   = '0;
         frame_sum    = '0;
         latest       = '0;
      end else begin
         // response first, so a stray beat never pairs with a frame closing this edge
         if (rsp.valid && rsp.ready) check_report();
         if (req.valid && req.ready) absorb_byte(req.rx_byte);
      end
      mismatches   <= error_total;
      reports_due  <= pending_reports.size();
      reports_seen <= beat_total;
   end

endmodule

[tb/tb_imu_serial_frame_decoder.sv]
module tb_imu_serial_frame_decoder;
   import imusfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_END   = 830;
   localparam int CALM_FROM    = 700;
   localparam int DRAIN_AT     = 400;

   logic clock = 1'b0;
   logic reset;
   bit   calm    = 1'b0;
   bit   gaps_on = 1'b1;
   int   sent_bytes  = 0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   reports_due;
   int   reports_seen;

   imusfd_req_if req_bus ();
   imusfd_rsp_if rsp_bus ();

   imu_serial_frame_decoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   imusfd_report_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .mismatches   (mismatch_count),
      .reports_due  (reports_due),
      .reports_seen (reports_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic put_byte(input logic [7:0] b);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_bytes++;
      @(negedge clock);
      if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] s0,
                             input logic [15:0] s1, input logic [15:0] s2, input bit bad_sum);
      logic [7:0] fr [11];
      logic [7:0] sum;
      fr[0]  = HEADER_BYTE;
      fr[1]  = kind_byte;
      fr[2]  = s0[7:0];
      fr[3]  = s0[15:8];
      fr[4]  = s1[7:0];
      fr[5]  = s1[15:8];
      fr[6]  = s2[7:0];
      fr[7]  = s2[15:8];
      fr[8]  = 8'($urandom);
      fr[9]  = 8'($urandom);
      sum    = '0;
      for (int i = 0; i < 10; i++) sum = sum + fr[i];
      fr[10] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < 11; i++) put_byte(fr[i]);
   endtask

   task automatic drain_reports();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (reports_due != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return {HEADER_BYTE, 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_kind_byte();
      logic [7:0] t;
      if ($urandom_range(0, 14) == 0) begin
         t = 8'($urandom);
         if (t >= TYPE_ACCEL && t <= TYPE_ANGLE) t = HEADER_BYTE;
         return t;
      end
      case ($urandom_range(0, 2))
         0:       return TYPE_ACCEL;
         1:       return TYPE_RATE;
         default: return TYPE_ANGLE;
      endcase
   endfunction

   // response side back-pressure
   initial begin
      int odds;
      rsp_bus.ready <= 1'b0;
      odds = 2;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) odds = $urandom_range(0, 3);
         if (!calm && $urandom_range(1, 12) <= odds) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      bit drained;
      int pick;
      drained = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle noise, then one frame per kind; data holds header bytes, last sum is wrong
      put_byte(8'hFF);
      put_byte(8'h00);
      send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h5555, 1'b0);
      send_frame(TYPE_RATE, 16'hFFFF, 16'h0000, 16'h0155, 1'b0);
      send_frame(TYPE_ANGLE, 16'h0102, 16'hFF80, 16'h7F00, 1'b1);
      drain_reports();

      while (sent_bytes < RANDOM_END) begin
         if ($urandom_range(0, 11) == 0) gaps_on = !gaps_on;
         if (sent_bytes >= CALM_FROM) calm = 1'b1;
         if (!drained && sent_bytes >= DRAIN_AT) begin
            drain_reports();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 15);
         if (pick < 11) begin
            send_frame(pick_kind_byte(), pick_count(), pick_count(), pick_count(),
                       $urandom_range(0, 9) == 0);
         end else if (pick < 14) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
         end else begin
            // cut-off frame, the next header lands inside it
            put_byte(HEADER_BYTE);
            repeat ($urandom_range(1, 9)) put_byte(8'($urandom));
         end
      end

      drain_reports();
      repeat (10) @(negedge clock);

      $display("run covered %0d bytes: all frame kinds, bad sums, unknown kinds, cut frames, noise",
               sent_bytes);
      $display("%0d frame reports compared, %0d field mismatches", reports_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
